[hdl/tsce_pkg.sv]
// ----------------------------------------------------------------------------
// tsce_pkg
// Shared codes for the server connection engine: operations, segment and
// reply types, connection states, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package tsce_pkg;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_OPEN    = 2'd1,
    OP_CONSUME = 2'd2,
    OP_CLOSE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    SEG_SYN     = 3'd0,
    SEG_SYNACK  = 3'd1,
    SEG_FIN     = 3'd2,
    SEG_FINACK  = 3'd3,
    SEG_DATA    = 3'd4,
    SEG_DATAACK = 3'd5
  } seg_t;

  typedef enum logic [1:0] {
    RPL_SYNACK  = 2'd0,
    RPL_FINACK  = 2'd1,
    RPL_DATAACK = 2'd2
  } reply_t;

  typedef enum logic [1:0] {
    CS_CLOSED = 2'd0,
    CS_LISTEN = 2'd1,
    CS_CONN   = 2'd2,
    CS_CWAIT  = 2'd3
  } conn_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_SLOT = 2'd1,
    STAT_SHORT   = 2'd2,
    STAT_DROP    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_UPDATE,
    S_OUT
  } fsm_t;

endpackage

`default_nettype wire

[hdl/tsce_if.sv]
// ----------------------------------------------------------------------------
// tsce_if
// Valid/ready channels of the server connection engine: the request item
// channel and the result item channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsce_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  slot;
  logic [15:0] listen_port;
  logic [2:0]  seg_type;
  logic [15:0] seg_src_port;
  logic [15:0] seg_dest_port;
  logic [31:0] seg_seq;
  logic [10:0] seg_len;
  logic [7:0]  seg_node;
  logic [16:0] consume_len;

  modport source (
    output valid, operation, slot, listen_port, seg_type, seg_src_port,
           seg_dest_port, seg_seq, seg_len, seg_node, consume_len,
    input  ready
  );
  modport sink (
    input  valid, operation, slot, listen_port, seg_type, seg_src_port,
           seg_dest_port, seg_seq, seg_len, seg_node, consume_len,
    output ready
  );
endinterface

interface tsce_out_if;
  logic        valid;
  logic        ready;
  logic        reply_valid;
  logic [1:0]  reply_type;
  logic [15:0] reply_src_port;
  logic [15:0] reply_dest_port;
  logic [31:0] reply_ack;
  logic [7:0]  reply_node;
  logic        store_valid;
  logic [15:0] store_offset;
  logic [2:0]  slot_out;
  logic [1:0]  status;

  modport source (
    output valid, reply_valid, reply_type, reply_src_port, reply_dest_port,
           reply_ack, reply_node, store_valid, store_offset, slot_out, status,
    input  ready
  );
  modport sink (
    input  valid, reply_valid, reply_type, reply_src_port, reply_dest_port,
           reply_ack, reply_node, store_valid, store_offset, slot_out, status,
    output ready
  );
endinterface

`default_nettype wire

[hdl/transport_server_connection_engine.sv]
// ----------------------------------------------------------------------------
// transport_server_connection_engine
// Server-side connection table: opens, closes and drains slots on host
// request and answers arriving segments (SYN, FIN, DATA) with reply items.
// ----------------------------------------------------------------------------
// Usage:
//   req  carries one item per host operation or arriving segment; it is
//        accepted when req.valid and req.ready are both high.
//   rsp  carries exactly one result item per request item (reply segment,
//        store location, slot and status).
//   Per-slot context sits in one RAM word per slot; only the in-use bits
//   are flops. A small sequencer drives one compare path and one shared
//   33-bit add/subtract unit.
// Sequencer steps:
//   segment / open : S_SCAN over k slots (1..SLOTS, one RAM read a cycle,
//                    stops at the first hit), then S_CALC (add), S_UPDATE
//                    and S_OUT, where rsp.valid is high.
//   consume / close: no scan; S_CALC, S_UPDATE, then S_OUT.
//   req.ready is high only while the engine is idle: one item at a time.
// Reset (rst, synchronous): every slot goes free, sequencer to idle, no
//   result pending. RAM contents are not cleared; an entry is always
//   written by an open before anything reads it.
// Stall: a finished result holds on rsp until rsp.ready; no new item is
//   taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module transport_server_connection_engine #(
  parameter int SLOTS     = 8,
  parameter int BUF_BYTES = 65536,
  parameter int MAX_DATA  = 1500
) (
  input wire logic   clk,
  input wire logic   rst,
  tsce_in_if.sink    req,
  tsce_out_if.source rsp
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index bits
  localparam int FW = $clog2(BUF_BYTES + 1);             // fill count bits
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [31:0]   BUF_LIMIT = 32'(BUF_BYTES);
  localparam logic [15:0]   MAX_LEN   = 16'(MAX_DATA);

  // one RAM word per slot
  typedef struct packed {
    logic [1:0]    cst;
    logic [15:0]   lport;
    logic [15:0]   pport;
    logic [7:0]    pnode;
    logic [31:0]   exp;
    logic [FW-1:0] fill;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // sequencer
  tsce_pkg::fsm_t state, state_next;
  logic [SW-1:0]  cur, cur_next;
  logic           found;
  logic [32:0]    calc;            // result of the first add step
  logic [SLOTS-1:0] in_use;

  // captured request item
  logic [1:0]  op;
  logic [15:0] listen_port;
  logic [2:0]  seg_type;
  logic [15:0] cli_port;
  logic [15:0] dst_port;
  logic [31:0] seq;
  logic [10:0] len;
  logic [7:0]  node;
  logic [16:0] want;

  // result register
  logic        r_reply_valid;
  logic [1:0]  r_reply_type;
  logic [15:0] r_reply_src;
  logic [15:0] r_reply_dest;
  logic [31:0] r_reply_ack;
  logic [7:0]  r_reply_node;
  logic        r_store_valid;
  logic [15:0] r_store_offset;
  logic [2:0]  r_slot;
  logic [1:0]  r_status;

  // RAM side
  logic [EW-1:0] ram_rdata;
  entry_t        rd;
  entry_t        wd;
  logic          upd_we;

  // shared adder
  logic [31:0] add_a, add_b;
  logic        add_sub;
  logic [32:0] add_sum;

  // update decisions
  logic        accept;
  logic        scan_hit;
  logic        use_set, use_clr;
  logic        n_reply_valid;
  logic [1:0]  n_reply_type;
  logic [15:0] n_reply_src;
  logic [15:0] n_reply_dest;
  logic [31:0] n_reply_ack;
  logic [7:0]  n_reply_node;
  logic        n_store_valid;
  logic [15:0] n_store_offset;
  logic [2:0]  n_slot;
  logic [1:0]  n_status;

  assign accept = req.valid && req.ready;
  assign rd     = entry_t'(ram_rdata);

  // RAM read address follows cur_next, so rd always shows entry cur
  tsce_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ctx (
    .clk   (clk),
    .we    ((state == tsce_pkg::S_UPDATE) && upd_we),
    .waddr (cur),
    .wdata (EW'(wd)),
    .raddr (cur_next),
    .rdata (ram_rdata)
  );

  // open looks for a free slot; a segment for the first in-use port match
  always_comb begin
    if (op == tsce_pkg::OP_OPEN) begin
      scan_hit = !in_use[cur];
    end else begin
      scan_hit = in_use[cur] && (rd.lport == dst_port);
    end
  end

  // shared add/subtract unit
  always_comb begin
    add_a   = seq;
    add_b   = 32'd1;
    add_sub = 1'b0;
    if (state == tsce_pkg::S_UPDATE) begin
      add_a = rd.exp;                      // expected + len
      add_b = 32'(len);
    end else if (op == tsce_pkg::OP_CONSUME) begin
      add_a   = 32'(rd.fill);              // fill - want, carry = no borrow
      add_b   = 32'(want);
      add_sub = 1'b1;
    end else if (seg_type == tsce_pkg::SEG_DATA) begin
      add_a = 32'(rd.fill);                // fill + len
      add_b = 32'(len);
    end
    add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 33'(add_sub);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tsce_pkg::S_IDLE: begin
        if (accept) begin
          if (req.operation == tsce_pkg::OP_SEGMENT ||
              req.operation == tsce_pkg::OP_OPEN) begin
            state_next = tsce_pkg::S_SCAN;
          end else begin
            state_next = tsce_pkg::S_CALC;
          end
        end
      end
      tsce_pkg::S_SCAN: begin
        if (scan_hit || cur == LAST_SLOT) begin
          state_next = tsce_pkg::S_CALC;
        end
      end
      tsce_pkg::S_CALC:   state_next = tsce_pkg::S_UPDATE;
      tsce_pkg::S_UPDATE: state_next = tsce_pkg::S_OUT;
      tsce_pkg::S_OUT: begin
        if (rsp.ready) begin
          state_next = tsce_pkg::S_IDLE;
        end
      end
      default: state_next = tsce_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cur_next = cur;
    if (state == tsce_pkg::S_IDLE && accept) begin
      if (req.operation == tsce_pkg::OP_SEGMENT ||
          req.operation == tsce_pkg::OP_OPEN) begin
        cur_next = '0;
      end else begin
        cur_next = SW'(req.slot);
      end
    end else if (state == tsce_pkg::S_SCAN && !scan_hit && cur != LAST_SLOT) begin
      cur_next = cur + 1'b1;
    end
  end

  // outputs
  always_comb begin
    req.ready           = (state == tsce_pkg::S_IDLE);
    rsp.valid           = (state == tsce_pkg::S_OUT);
    rsp.reply_valid     = r_reply_valid;
    rsp.reply_type      = r_reply_type;
    rsp.reply_src_port  = r_reply_src;
    rsp.reply_dest_port = r_reply_dest;
    rsp.reply_ack       = r_reply_ack;
    rsp.reply_node      = r_reply_node;
    rsp.store_valid     = r_store_valid;
    rsp.store_offset    = r_store_offset;
    rsp.slot_out        = r_slot;
    rsp.status          = r_status;
  end

  // entry update and result for the slot at cur
  always_comb begin
    wd             = rd;
    upd_we         = 1'b0;
    use_set        = 1'b0;
    use_clr        = 1'b0;
    n_reply_valid  = 1'b0;
    n_reply_type   = tsce_pkg::RPL_SYNACK;
    n_reply_src    = '0;
    n_reply_dest   = '0;
    n_reply_ack    = '0;
    n_reply_node   = '0;
    n_store_valid  = 1'b0;
    n_store_offset = '0;
    n_slot         = '0;
    n_status       = tsce_pkg::STAT_OK;
    unique case (op)
      tsce_pkg::OP_SEGMENT: begin
        if (!found) begin
          n_status = tsce_pkg::STAT_NO_SLOT;
        end else begin
          n_slot = 3'(cur);
          unique case (rd.cst)
            tsce_pkg::CS_LISTEN: begin
              if (seg_type == tsce_pkg::SEG_SYN) begin
                wd.pport      = cli_port;
                wd.pnode      = node;
                wd.cst        = tsce_pkg::CS_CONN;
                wd.exp        = calc[31:0];
                upd_we        = 1'b1;
                n_reply_valid = 1'b1;
                n_reply_type  = tsce_pkg::RPL_SYNACK;
                n_reply_src   = rd.lport;
                n_reply_dest  = cli_port;
                n_reply_ack   = calc[31:0];
                n_reply_node  = node;
              end
            end
            tsce_pkg::CS_CONN: begin
              n_reply_src  = rd.lport;
              n_reply_dest = rd.pport;
              n_reply_node = rd.pnode;
              if (seg_type == tsce_pkg::SEG_SYN) begin
                wd.exp        = calc[31:0];
                upd_we        = 1'b1;
                n_reply_valid = 1'b1;
                n_reply_type  = tsce_pkg::RPL_SYNACK;
                n_reply_ack   = calc[31:0];
              end else if (seg_type == tsce_pkg::SEG_FIN) begin
                wd.cst        = tsce_pkg::CS_CWAIT;
                upd_we        = 1'b1;
                n_reply_valid = 1'b1;
                n_reply_type  = tsce_pkg::RPL_FINACK;
              end else if (seg_type == tsce_pkg::SEG_DATA) begin
                if (16'(len) > MAX_LEN || calc[31:0] > BUF_LIMIT) begin
                  n_status = tsce_pkg::STAT_DROP;     // dropped, no reply
                end else if (rd.exp == seq) begin
                  wd.exp         = add_sum[31:0];
                  wd.fill        = FW'(calc[31:0]);
                  upd_we         = 1'b1;
                  n_store_valid  = 1'b1;
                  n_store_offset = 16'(rd.fill);
                  n_reply_valid  = 1'b1;
                  n_reply_type   = tsce_pkg::RPL_DATAACK;
                  n_reply_ack    = add_sum[31:0];
                end else begin
                  // out of sequence: re-ack what we expect
                  n_reply_valid = 1'b1;
                  n_reply_type  = tsce_pkg::RPL_DATAACK;
                  n_reply_ack   = rd.exp;
                  n_status      = tsce_pkg::STAT_DROP;
                end
              end
              if (!n_reply_valid) begin
                n_reply_src  = '0;
                n_reply_dest = '0;
                n_reply_node = '0;
              end
            end
            tsce_pkg::CS_CWAIT: begin
              if (seg_type == tsce_pkg::SEG_FIN) begin
                n_reply_valid = 1'b1;
                n_reply_type  = tsce_pkg::RPL_FINACK;
                n_reply_src   = rd.lport;
                n_reply_dest  = rd.pport;
                n_reply_node  = rd.pnode;
              end
            end
            tsce_pkg::CS_CLOSED: begin
              n_status = tsce_pkg::STAT_OK;
            end
            default: n_status = tsce_pkg::STAT_OK;
          endcase
        end
      end
      tsce_pkg::OP_OPEN: begin
        if (found) begin
          use_set  = 1'b1;
          wd.cst   = tsce_pkg::CS_LISTEN;
          wd.lport = listen_port;
          wd.fill  = '0;
          upd_we   = 1'b1;
          n_slot   = 3'(cur);
        end else begin
          n_status = tsce_pkg::STAT_NO_SLOT;
        end
      end
      tsce_pkg::OP_CONSUME: begin
        if (!found || !in_use[cur]) begin
          n_status = tsce_pkg::STAT_NO_SLOT;
        end else begin
          n_slot = 3'(cur);
          if (calc[32]) begin
            wd.fill = FW'(calc[31:0]);
            upd_we  = 1'b1;
          end else begin
            n_status = tsce_pkg::STAT_SHORT;
          end
        end
      end
      tsce_pkg::OP_CLOSE: begin
        if (!found || !in_use[cur]) begin
          n_status = tsce_pkg::STAT_NO_SLOT;
        end else begin
          n_slot = 3'(cur);
          if (rd.cst == tsce_pkg::CS_CWAIT || rd.cst == tsce_pkg::CS_CLOSED) begin
            use_clr = 1'b1;
            wd.cst  = tsce_pkg::CS_CLOSED;
            wd.fill = '0;
            upd_we  = 1'b1;
          end else begin
            n_status = tsce_pkg::STAT_DROP;   // close refused
          end
        end
      end
      default: n_status = tsce_pkg::STAT_OK;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tsce_pkg::S_IDLE;
      cur    <= '0;
      in_use <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      if (state == tsce_pkg::S_UPDATE && use_set) begin
        in_use[cur] <= 1'b1;
      end
      if (state == tsce_pkg::S_UPDATE && use_clr) begin
        in_use[cur] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= req.operation;
      listen_port <= req.listen_port;
      seg_type    <= req.seg_type;
      cli_port    <= req.seg_src_port;
      dst_port    <= req.seg_dest_port;
      seq         <= req.seg_seq;
      len         <= req.seg_len;
      node        <= req.seg_node;
      want        <= req.consume_len;
      found       <= (32'(req.slot) < 32'(SLOTS));
    end else if (state == tsce_pkg::S_SCAN) begin
      found <= scan_hit;
    end
    if (state == tsce_pkg::S_CALC) begin
      calc <= add_sum;
    end
    if (state == tsce_pkg::S_UPDATE) begin
      r_reply_valid  <= n_reply_valid;
      r_reply_type   <= n_reply_type;
      r_reply_src    <= n_reply_src;
      r_reply_dest   <= n_reply_dest;
      r_reply_ack    <= n_reply_ack;
      r_reply_node   <= n_reply_node;
      r_store_valid  <= n_store_valid;
      r_store_offset <= n_store_offset;
      r_slot         <= n_slot;
      r_status       <= n_status;
    end
  end

endmodule

`default_nettype wire

[hdl/tsce_ram.sv]
// ----------------------------------------------------------------------------
// tsce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the server connection engine. A directed table
// walks the corner cases (empty table, port and sequence extremes, refused
// close, drops, close-wait), then random connection sessions, bulk
// transfers, table fill-ups, sweeps and noise run against a shadow copy of
// the connection table. Every result item is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import tsce_pkg::*;

  localparam int NSLOT        = 8;
  localparam int BUF_LIMIT    = 65536;
  localparam int MAX_SEG      = 1500;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 20;

  // one request item as offered on req
  typedef struct {
    op_t         op;
    logic [2:0]  slot;
    logic [15:0] lport_in;
    seg_t        stype;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] seq;
    logic [10:0] len;
    logic [7:0]  node;
    logic [16:0] clen;
  } conn_request_t;

  // one result item as seen on rsp
  typedef struct {
    logic        reply_valid;
    reply_t      reply_type;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic [31:0] reply_ack;
    logic [7:0]  reply_node;
    logic        store_valid;
    logic [15:0] store_offset;
    logic [2:0]  slot_out;
    status_t     status;
  } conn_result_t;

  typedef struct {
    conn_request_t req;
    bit            typed;   // row carries a hand-written result
    conn_result_t  res;
  } stim_row_t;

  // receiver ready patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsce_in_if  req_ch ();
  tsce_out_if rsp_ch ();

  transport_server_connection_engine #(
    .SLOTS    (NSLOT),
    .BUF_BYTES(BUF_LIMIT),
    .MAX_DATA (MAX_SEG)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow connection table, updated when an item is accepted.
  bit          in_use  [NSLOT];
  conn_t       cstate  [NSLOT];
  logic [15:0] lport   [NSLOT];
  logic [15:0] pport   [NSLOT];
  logic [7:0]  pnode   [NSLOT];
  logic [31:0] ack_next[NSLOT];
  int unsigned fill    [NSLOT];

  conn_result_t reply_q[$];     // results owed by the engine, oldest first
  stim_row_t    stim_rows[$];

  int errors, n_items, n_results, burst_left;
  int op_count[4];
  int seg_count[6];
  int n_reply, n_store, n_noslot, n_short, n_refused;

  // --------------------------------------------------------------------------
  // item and result builders
  // --------------------------------------------------------------------------
  function automatic logic [10:0] pick_len();
    int p;
    p = $urandom_range(0, 19);
    if (p < 14) return $urandom_range(0, 200);
    if (p < 18) return $urandom_range(201, MAX_SEG);
    if (p == 18) return MAX_SEG;
    return $urandom_range(MAX_SEG + 1, 2047);   // oversize, gets dropped
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd80;
      3: return 16'd443;
      default: return $urandom;
    endcase
  endfunction

  // fully random item; also supplies junk for the fields an op ignores
  function automatic conn_request_t random_request();
    conn_request_t r;
    r.op       = op_t'($urandom_range(0, 3));
    r.slot     = $urandom_range(0, 7);
    r.lport_in = $urandom;
    r.stype    = seg_t'($urandom_range(0, 5));
    r.src      = $urandom;
    r.dst      = $urandom;
    r.seq      = $urandom;
    r.len      = pick_len();
    r.node     = $urandom;
    r.clen     = $urandom_range(0, 65536);
    return r;
  endfunction

  function automatic conn_request_t mk_seg(seg_t t, logic [15:0] src, logic [15:0] dst,
                                           logic [31:0] seq, logic [10:0] len,
                                           logic [7:0] node);
    conn_request_t r;
    r       = random_request();
    r.op    = OP_SEGMENT;
    r.stype = t;
    r.src   = src;
    r.dst   = dst;
    r.seq   = seq;
    r.len   = len;
    r.node  = node;
    return r;
  endfunction

  function automatic conn_request_t mk_host(op_t op, logic [2:0] sl, logic [15:0] port,
                                            logic [16:0] clen);
    conn_request_t r;
    r          = random_request();
    r.op       = op;
    r.slot     = sl;
    r.lport_in = port;
    r.clen     = clen;
    return r;
  endfunction

  function automatic conn_result_t mk_res(logic rv, reply_t rt, logic [15:0] sp,
                                          logic [15:0] dp, logic [31:0] ack,
                                          logic [7:0] nd, logic sv, logic [15:0] off,
                                          logic [2:0] sl, status_t st);
    conn_result_t o;
    o.reply_valid     = rv;
    o.reply_type      = rt;
    o.reply_src_port  = sp;
    o.reply_dest_port = dp;
    o.reply_ack       = ack;
    o.reply_node      = nd;
    o.store_valid     = sv;
    o.store_offset    = off;
    o.slot_out        = sl;
    o.status          = st;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // shadow table queries and the engine predictor
  // --------------------------------------------------------------------------
  function automatic int port_owner(logic [15:0] port);
    for (int i = 0; i < NSLOT; i++)
      if (in_use[i] && lport[i] == port) return i;
    return -1;
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += in_use[i];
    return n;
  endfunction

  function automatic conn_result_t with_reply(conn_result_t o, int s, reply_t t,
                                              logic [31:0] ack);
    o.reply_valid     = 1'b1;
    o.reply_type      = t;
    o.reply_src_port  = lport[s];
    o.reply_dest_port = pport[s];
    o.reply_ack       = ack;
    o.reply_node      = pnode[s];
    return o;
  endfunction

  function automatic conn_result_t engine_predict(conn_request_t r);
    conn_result_t o;
    int hit;
    o   = mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_OK);
    hit = -1;
    case (r.op)
      OP_SEGMENT: begin
        hit = port_owner(r.dst);
        if (hit < 0) begin
          o.status = STAT_NO_SLOT;
        end else begin
          o.slot_out = 3'(hit);
          case (cstate[hit])
            CS_LISTEN: begin
              // first SYN latches the peer and opens the connection
              if (r.stype == SEG_SYN) begin
                pport[hit]    = r.src;
                pnode[hit]    = r.node;
                cstate[hit]   = CS_CONN;
                ack_next[hit] = r.seq + 32'd1;
                o = with_reply(o, hit, RPL_SYNACK, ack_next[hit]);
              end
            end
            CS_CONN: begin
              if (r.stype == SEG_SYN) begin
                // resync: peer stays, sequence restarts
                ack_next[hit] = r.seq + 32'd1;
                o = with_reply(o, hit, RPL_SYNACK, ack_next[hit]);
              end else if (r.stype == SEG_FIN) begin
                cstate[hit] = CS_CWAIT;
                o = with_reply(o, hit, RPL_FINACK, 32'd0);
              end else if (r.stype == SEG_DATA) begin
                if (r.len > MAX_SEG || fill[hit] + r.len > BUF_LIMIT) begin
                  o.status = STAT_DROP;
                end else if (ack_next[hit] == r.seq) begin
                  o.store_valid  = 1'b1;
                  o.store_offset = fill[hit][15:0];
                  ack_next[hit] += 32'(r.len);
                  fill[hit]     += r.len;
                  o = with_reply(o, hit, RPL_DATAACK, ack_next[hit]);
                end else begin
                  // out of sequence: re-ack the expected number
                  o = with_reply(o, hit, RPL_DATAACK, ack_next[hit]);
                  o.status = STAT_DROP;
                end
              end
            end
            CS_CWAIT: begin
              if (r.stype == SEG_FIN) o = with_reply(o, hit, RPL_FINACK, 32'd0);
            end
            default: ;
          endcase
        end
      end
      OP_OPEN: begin
        for (int i = 0; i < NSLOT; i++)
          if (hit < 0 && !in_use[i]) hit = i;
        if (hit < 0) begin
          o.status = STAT_NO_SLOT;
        end else begin
          in_use[hit] = 1'b1;
          cstate[hit] = CS_LISTEN;
          lport[hit]  = r.lport_in;
          fill[hit]   = 0;
          o.slot_out  = 3'(hit);
        end
      end
      default: begin
        if (!in_use[r.slot]) begin
          o.status = STAT_NO_SLOT;
        end else if (r.op == OP_CONSUME) begin
          o.slot_out = r.slot;
          if (fill[r.slot] >= r.clen) fill[r.slot] -= r.clen;
          else o.status = STAT_SHORT;
        end else begin
          o.slot_out = r.slot;
          if (cstate[r.slot] == CS_CWAIT) begin
            fill[r.slot]   = 0;
            cstate[r.slot] = CS_CLOSED;
          end
          if (cstate[r.slot] == CS_CLOSED) begin
            in_use[r.slot] = 1'b0;
            fill[r.slot]   = 0;
          end else begin
            o.status = STAT_DROP;   // close refused while live
          end
        end
      end
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // request side: bursts with random gaps, one item per handshake
  // --------------------------------------------------------------------------
  task automatic offer(conn_request_t r, bit typed, conn_result_t e);
    conn_result_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        req_ch.valid = 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.operation     = r.op;
    req_ch.slot          = r.slot;
    req_ch.listen_port   = r.lport_in;
    req_ch.seg_type      = r.stype;
    req_ch.seg_src_port  = r.src;
    req_ch.seg_dest_port = r.dst;
    req_ch.seg_seq       = r.seq;
    req_ch.seg_len       = r.len;
    req_ch.seg_node      = r.node;
    req_ch.consume_len   = r.clen;
    req_ch.valid         = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    p = engine_predict(r);
    reply_q.push_back(typed ? e : p);
    n_items++;
    op_count[r.op]++;
    if (r.op == OP_SEGMENT) seg_count[r.stype]++;
    n_reply   += p.reply_valid;
    n_store   += p.store_valid;
    n_noslot  += (p.status == STAT_NO_SLOT);
    n_short   += (p.status == STAT_SHORT);
    n_refused += (p.status == STAT_DROP);
    // valid stays up; the next offer either drops it for a gap or reloads
    @(negedge clk);
  endtask

  task automatic send(conn_request_t r);
    offer(r, 1'b0, mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_OK));
  endtask

  function automatic logic [16:0] consume_amount(int s);
    int p;
    if (s < 0) return $urandom_range(0, 65536);
    p = $urandom_range(0, 9);
    if (p < 7) return $urandom_range(0, fill[s]);
    if (p < 9) return (fill[s] + 100 > 65536) ? 17'd65536 : fill[s] + $urandom_range(1, 100);
    return $urandom_range(0, 65536);
  endfunction

  // --------------------------------------------------------------------------
  // random scenarios
  // --------------------------------------------------------------------------
  // open, handshake, mixed traffic and host ops, then FIN and close
  task automatic connection_session();
    logic [15:0] port, src;
    logic [7:0]  node;
    logic [31:0] seq;
    int s, pick;
    port = pick_port();
    src  = $urandom;
    node = $urandom;
    seq  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
    send(mk_host(OP_OPEN, $urandom, port, $urandom));
    send(mk_seg(SEG_SYN, src, port, seq, pick_len(), node));
    repeat ($urandom_range(1, 20)) begin
      s    = port_owner(port);
      seq  = (s >= 0) ? ack_next[s] : $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send(mk_seg(SEG_DATA, src, port, seq, pick_len(), node));
      else if (pick < 65)
        send(mk_seg(SEG_DATA, src, port, seq + $urandom_range(1, 5000), pick_len(), node));
      else if (pick < 80)
        send(mk_host(OP_CONSUME, (s >= 0) ? 3'(s) : 3'($urandom), 0, consume_amount(s)));
      else if (pick < 85)
        send(mk_seg(SEG_SYN, $urandom, port, $urandom, pick_len(), $urandom));
      else if (pick < 93)   // SYNACK, FINACK or DATAACK: ignored by a server
        send(mk_seg(seg_t'(1 + 2 * $urandom_range(0, 2)), src, port, $urandom,
                    pick_len(), node));
      else
        send(mk_host(OP_CLOSE, (s >= 0) ? 3'(s) : 3'($urandom), 0, 0));
    end
    s = port_owner(port);
    if ($urandom_range(0, 9) != 0) send(mk_seg(SEG_FIN, src, port, $urandom, 0, node));
    if ($urandom_range(0, 4) == 0) send(mk_seg(SEG_FIN, src, port, $urandom, 0, node));
    if ($urandom_range(0, 6) != 0)
      send(mk_host(OP_CLOSE, (s >= 0) ? 3'(s) : 3'($urandom), 0, 0));
  endtask

  // fill one receive buffer to the brim to reach the overflow drop
  task automatic bulk_session();
    logic [15:0] port, src;
    logic [7:0]  node;
    int s;
    port = pick_port();
    src  = $urandom;
    node = $urandom;
    send(mk_host(OP_OPEN, $urandom, port, 0));
    send(mk_seg(SEG_SYN, src, port, $urandom, 0, node));
    s = port_owner(port);
    if (s < 0 || cstate[s] != CS_CONN) return;
    for (int k = 0; k < 50 && fill[s] + MAX_SEG <= BUF_LIMIT; k++)
      send(mk_seg(SEG_DATA, src, port, ack_next[s], MAX_SEG, node));
    send(mk_seg(SEG_DATA, src, port, ack_next[s], MAX_SEG, node));
    send(mk_seg(SEG_DATA, src, port, ack_next[s], 11'(BUF_LIMIT - fill[s]), node));
    // buffer exactly full: empty item still fits, one byte more does not
    send(mk_seg(SEG_DATA, src, port, ack_next[s], 0, node));
    send(mk_seg(SEG_DATA, src, port, ack_next[s], 1, node));
    send(mk_host(OP_CONSUME, 3'(s), 0, 17'd65536));
    send(mk_host(OP_CONSUME, 3'(s), 0, consume_amount(s)));
    send(mk_seg(SEG_FIN, src, port, $urandom, 0, node));
    send(mk_host(OP_CLOSE, 3'(s), 0, 0));
  endtask

  // walk every live slot down to free: SYN a listener, FIN a connection
  task automatic sweep();
    for (int s = 0; s < NSLOT; s++)
      for (int k = 0; k < 4 && in_use[s]; k++)
        case (cstate[s])
          CS_LISTEN: send(mk_seg(SEG_SYN, $urandom, lport[s], $urandom, pick_len(), $urandom));
          CS_CONN:   send(mk_seg(SEG_FIN, $urandom, lport[s], $urandom, pick_len(), $urandom));
          default:   send(mk_host(OP_CLOSE, 3'(s), $urandom, $urandom));
        endcase
  endtask

  task automatic fill_session();
    for (int k = 0; k < NSLOT && used_count() < NSLOT; k++)
      send(mk_host(OP_OPEN, $urandom, pick_port(), $urandom));
    send(mk_host(OP_OPEN, $urandom, pick_port(), $urandom));   // table full
    sweep();
  endtask

  task automatic noise_burst();
    conn_request_t r;
    int s;
    repeat ($urandom_range(1, 8)) begin
      r = random_request();
      s = $urandom_range(0, NSLOT - 1);
      if (in_use[s] && $urandom_range(0, 1)) r.dst = lport[s];
      send(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: ready pattern, long hold-offs, and the checker
  // --------------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int left, cyc, hold;
    rsp_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    cyc  = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      cyc++;
      // long stall while the sender keeps offering: the engine must back up
      if (cyc == 2000 || cyc == 12000) hold = 400;
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(50, 300);
      end
      left--;
      if (hold > 0) begin
        hold--;
        rsp_ch.ready = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   rsp_ch.ready = 1'b1;
          RX_COIN:   rsp_ch.ready = $urandom_range(0, 1);
          RX_COMB:   rsp_ch.ready = (cyc % 7) >= 3;
          default:   rsp_ch.ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  initial begin
    conn_result_t e;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        n_results++;
        if (reply_q.size() == 0) begin
          $error("result item with no request outstanding");
          errors++;
        end else begin
          e = reply_q.pop_front();
          field_check("reply_valid", e.reply_valid, rsp_ch.reply_valid);
          field_check("reply_type", e.reply_type, rsp_ch.reply_type);
          field_check("reply_src_port", e.reply_src_port, rsp_ch.reply_src_port);
          field_check("reply_dest_port", e.reply_dest_port, rsp_ch.reply_dest_port);
          field_check("reply_ack", e.reply_ack, rsp_ch.reply_ack);
          field_check("reply_node", e.reply_node, rsp_ch.reply_node);
          field_check("store_valid", e.store_valid, rsp_ch.store_valid);
          field_check("store_offset", e.store_offset, rsp_ch.store_offset);
          field_check("slot_out", e.slot_out, rsp_ch.slot_out);
          field_check("status", e.status, rsp_ch.status);
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  task automatic add_row(conn_request_t r, bit typed, conn_result_t e);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.res   = e;
    stim_rows.push_back(row);
  endtask

  initial begin
    conn_result_t nil;
    int pick;
    req_ch.valid         = 1'b0;
    req_ch.operation     = OP_SEGMENT;
    req_ch.slot          = '0;
    req_ch.listen_port   = '0;
    req_ch.seg_type      = SEG_SYN;
    req_ch.seg_src_port  = '0;
    req_ch.seg_dest_port = '0;
    req_ch.seg_seq       = '0;
    req_ch.seg_len       = '0;
    req_ch.seg_node      = '0;
    req_ch.consume_len   = '0;
    for (int i = 0; i < NSLOT; i++) begin
      in_use[i]   = 1'b0;
      cstate[i]   = CS_CLOSED;
      lport[i]    = '0;
      pport[i]    = '0;
      pnode[i]    = '0;
      ack_next[i] = '0;
      fill[i]     = 0;
    end
    nil = mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_OK);

    // Directed rows. Slot 0 listens on 0xFFFF and goes through its whole
    // life; slot 1 listens on port 0 and takes a resync SYN.
    add_row(mk_host(OP_CLOSE, 0, 0, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_NO_SLOT));
    add_row(mk_seg(SEG_SYN, 16'h1234, 16'h1234, 0, 0, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_NO_SLOT));
    add_row(mk_host(OP_OPEN, 0, 16'hFFFF, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_OK));
    add_row(mk_host(OP_OPEN, 0, 16'h0000, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 1, STAT_OK));
    // SYN at the top of sequence space: ack wraps to zero
    add_row(mk_seg(SEG_SYN, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 8'hFF), 1,
            mk_res(1, RPL_SYNACK, 16'hFFFF, 16'hFFFF, 0, 8'hFF, 0, 0, 0, STAT_OK));
    add_row(mk_seg(SEG_DATA, 16'hFFFF, 16'hFFFF, 0, 11'd1500, 8'hFF), 1,
            mk_res(1, RPL_DATAACK, 16'hFFFF, 16'hFFFF, 1500, 8'hFF, 1, 0, 0, STAT_OK));
    // longer than the largest segment: dropped silently
    add_row(mk_seg(SEG_DATA, 16'hFFFF, 16'hFFFF, 1500, 11'd2047, 8'hFF), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_DROP));
    // out of sequence: re-acked, not stored
    add_row(mk_seg(SEG_DATA, 16'hFFFF, 16'hFFFF, 5, 11'd10, 8'hFF), 1,
            mk_res(1, RPL_DATAACK, 16'hFFFF, 16'hFFFF, 1500, 8'hFF, 0, 0, 0, STAT_DROP));
    add_row(mk_seg(SEG_DATA, 16'hFFFF, 16'hFFFF, 1500, 0, 8'hFF), 0, nil);
    add_row(mk_seg(SEG_SYNACK, 16'hFFFF, 16'hFFFF, 0, 0, 0), 0, nil);
    add_row(mk_seg(SEG_DATAACK, 16'hFFFF, 16'hFFFF, 0, 0, 0), 0, nil);
    add_row(mk_seg(SEG_FINACK, 16'hFFFF, 16'hFFFF, 0, 0, 0), 0, nil);
    add_row(mk_host(OP_CONSUME, 0, 0, 17'd1501), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_SHORT));
    add_row(mk_host(OP_CONSUME, 0, 0, 17'd1500), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_OK));
    add_row(mk_host(OP_CLOSE, 0, 0, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_DROP));
    add_row(mk_seg(SEG_FIN, 16'hFFFF, 16'hFFFF, 0, 0, 0), 1,
            mk_res(1, RPL_FINACK, 16'hFFFF, 16'hFFFF, 0, 8'hFF, 0, 0, 0, STAT_OK));
    add_row(mk_seg(SEG_FIN, 16'hFFFF, 16'hFFFF, 0, 0, 0), 1,
            mk_res(1, RPL_FINACK, 16'hFFFF, 16'hFFFF, 0, 8'hFF, 0, 0, 0, STAT_OK));
    add_row(mk_seg(SEG_DATA, 16'hFFFF, 16'hFFFF, 1500, 11'd1, 8'hFF), 0, nil);
    add_row(mk_host(OP_CLOSE, 0, 0, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_OK));
    add_row(mk_host(OP_CONSUME, 0, 0, 0), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 0, STAT_NO_SLOT));
    add_row(mk_seg(SEG_SYN, 0, 0, 0, 0, 0), 1,
            mk_res(1, RPL_SYNACK, 0, 0, 1, 0, 0, 0, 1, STAT_OK));
    // resync keeps the first peer's port and node
    add_row(mk_seg(SEG_SYN, 16'd5, 0, 32'h7FFF_FFFF, 0, 8'd9), 1,
            mk_res(1, RPL_SYNACK, 0, 0, 32'h8000_0000, 0, 0, 0, 1, STAT_OK));
    add_row(mk_host(OP_CONSUME, 1, 0, 17'd65536), 1,
            mk_res(0, RPL_SYNACK, 0, 0, 0, 0, 0, 0, 1, STAT_SHORT));
    add_row(mk_host(OP_OPEN, 0, 16'h8001, 0), 0, nil);
    add_row(mk_seg(SEG_FIN, 16'd7, 16'h8001, 0, 0, 8'd7), 0, nil);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_rows[i]) offer(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);

    // random part: mostly whole sessions, some bulk, fills, sweeps and noise
    while (n_items < stim_rows.size() + RANDOM_ITEMS) begin
      if (used_count() >= 6) sweep();
      pick = $urandom_range(0, 99);
      if (pick < 55)      connection_session();
      else if (pick < 63) bulk_session();
      else if (pick < 68) fill_session();
      else if (pick < 78) sweep();
      else                noise_burst();
    end
    req_ch.valid = 1'b0;

    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (segment %0d, open %0d, consume %0d, close %0d), %0d results",
             n_items, op_count[OP_SEGMENT], op_count[OP_OPEN], op_count[OP_CONSUME],
             op_count[OP_CLOSE], n_results);
    $display("SYN/SYNACK/FIN/FINACK/DATA/DATAACK %0d/%0d/%0d/%0d/%0d/%0d; replies %0d, stores %0d, no-slot %0d, short %0d, refused or dropped %0d",
             seg_count[0], seg_count[1], seg_count[2], seg_count[3], seg_count[4],
             seg_count[5], n_reply, n_store, n_noslot, n_short, n_refused);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
